FILE: rtl/drt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_pkg
// Shared constants, codes and types for the demand reference tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

	localparam int PRODUCTS_DEF   = 64;
	localparam int COUNT_BITS_DEF = 16;
	localparam int LANES          = 4;

	localparam int KIND_W   = 2;
	localparam int PROD_W   = 6;
	localparam int SRC_W    = 2;
	localparam int COUNT_W  = 16;
	localparam int TOTAL_W  = 18;
	localparam int REV_W    = 32;
	localparam int MASK_W   = 64;
	localparam int STATUS_W = 2;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 136;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam kind_t KIND_ACQUIRE = 2'd0;
	localparam kind_t KIND_RELEASE = 2'd1;
	localparam kind_t KIND_QUERY   = 2'd2;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_REL_ZERO  = 2'd1;
	localparam status_t STATUS_SATURATED = 2'd2;

	// Side effects of one update on the stored state
	typedef struct packed {
		logic write;      // counter word changed, write it back
		logic bump;       // active set changed, advance revision
		logic set_active; // product went from idle to active
		logic clr_active; // product went from active to idle
	} upd_flags_t;

endpackage

FILE: rtl/drt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/drt_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_update
// Read-modify-write of one product's counter word for a single request.
// ----------------------------------------------------------------------------
module drt_update
	import drt_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int WORD_W    = LANES * COUNT_BITS
) (
	input  kind_t              kind,
	input  logic [SRC_W-1:0]   source,
	input  logic               in_range,
	input  logic [WORD_W-1:0]  word,
	output logic [WORD_W-1:0]  new_word,
	output logic [COUNT_W-1:0] source_count,
	output logic [TOTAL_W-1:0] product_total,
	output status_t            status,
	output upd_flags_t         flags
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] cnt_old;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [TOTAL_W-1:0]    total_old;
	logic [TOTAL_W-1:0]    total_new;

	always_comb begin
		cnt_old   = word[source*COUNT_BITS +: COUNT_BITS];
		total_old = '0;
		for (int l = 0; l < LANES; l++) begin
			total_old = total_old + TOTAL_W'(word[l*COUNT_BITS +: COUNT_BITS]);
		end
	end

	always_comb begin
		cnt_new = cnt_old;
		status  = STATUS_OK;
		flags   = '0;
		if (in_range) begin
			if (kind == KIND_ACQUIRE) begin
				if (cnt_old == COUNT_MAX) begin
					status = STATUS_SATURATED;
				end else begin
					cnt_new          = cnt_old + 1'b1;
					flags.write      = 1'b1;
					flags.bump       = (total_old == '0);
					flags.set_active = (total_old == '0);
				end
			end else if (kind == KIND_RELEASE) begin
				if (cnt_old == '0) begin
					status = STATUS_REL_ZERO;
				end else begin
					cnt_new          = cnt_old - 1'b1;
					flags.write      = 1'b1;
					// total drops by one: it reaches zero only from one
					flags.bump       = (total_old == TOTAL_W'(1));
					flags.clr_active = (total_old == TOTAL_W'(1));
				end
			end
		end
	end

	always_comb begin
		new_word = word;
		new_word[source*COUNT_BITS +: COUNT_BITS] = cnt_new;
		total_new = '0;
		for (int l = 0; l < LANES; l++) begin
			total_new = total_new + TOTAL_W'(new_word[l*COUNT_BITS +: COUNT_BITS]);
		end
		source_count  = in_range ? COUNT_W'(cnt_new) : '0;
		product_total = in_range ? total_new : '0;
	end

endmodule

FILE: rtl/demand_reference_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_reference_tracker_top
// Per-product, per-source demand counters with an active-set revision.
// ----------------------------------------------------------------------------
// Path: a request's RAM read is registered at the accepting edge along with
//   its stage 1 payload; the update then runs on that word and its result
//   lands in the result register that drives the master side.
// Throughput: one request per cycle while the master side drains results; the
//   single RAM read port and the write-back forwarding path set this figure.
// Reset: the per-entry valid bits, the active mask, the revision and all
//   handshake state clear at once; entries never written read as zero, so
//   no clearing pass is needed and requests are taken from the first cycle.
// ----------------------------------------------------------------------------
module demand_reference_tracker_top
	import drt_pkg::*;
#(
	parameter int PRODUCTS   = PRODUCTS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // kind[1:0], product[7:2], source[9:8]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // source_count[15:0], product_total[33:16],
	                                        // revision[65:34], active_mask[129:66],
	                                        // status[131:130]
);

	localparam int PA     = (PRODUCTS > 1) ? $clog2(PRODUCTS) : 1;
	localparam int WORD_W = LANES * COUNT_BITS;

	// Unpack the incoming transaction
	kind_t             in_kind;
	logic [PROD_W-1:0] in_prod;
	logic [SRC_W-1:0]  in_src;
	logic              in_range;
	logic [PA-1:0]     in_idx;
	logic              in_acc;

	assign in_kind  = s_tdata[1:0];
	assign in_prod  = s_tdata[7:2];
	assign in_src   = s_tdata[9:8];
	assign in_range = ({1'b0, in_prod} < (PROD_W + 1)'(PRODUCTS));
	assign in_idx   = in_prod[PA-1:0];
	assign in_acc   = s_tvalid && s_tready;

	// Stage 1: request waiting on RAM read data
	logic              s1_valid_q;
	kind_t             kind_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [SRC_W-1:0]  src_s1;
	logic              range_s1;
	logic              rd_valid_s1;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwd_word_s1;
	logic              s1_adv;

	// State
	logic [PRODUCTS-1:0] vld_q;
	logic [PRODUCTS-1:0] active_q;
	logic [REV_W-1:0]    revision_q;

	// Update path
	logic [WORD_W-1:0]  ram_rdata;
	logic [WORD_W-1:0]  cur_word;
	logic [WORD_W-1:0]  new_word;
	logic [COUNT_W-1:0] upd_count;
	logic [TOTAL_W-1:0] upd_total;
	status_t            upd_status;
	upd_flags_t         upd_flags;
	logic               ram_we;
	logic [PRODUCTS-1:0] prod_bit;
	logic [PRODUCTS-1:0] active_next;
	logic [REV_W-1:0]    revision_next;

	// Output register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	// Advance stage 1 whenever the result register is free or being drained
	assign s1_adv   = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign ram_we   = s1_adv && upd_flags.write;

	drt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (PRODUCTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (prod_s1[PA-1:0]),
		.wdata (new_word),
		.re    (in_acc),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	// Take the word written back in the same edge ahead of the stale RAM read;
	// an entry never written reads as zero
	always_comb begin
		priority if (fwd_s1) begin
			cur_word = fwd_word_s1;
		end else if (rd_valid_s1) begin
			cur_word = ram_rdata;
		end else begin
			cur_word = '0;
		end
	end

	drt_update #(
		.COUNT_BITS (COUNT_BITS)
	) u_update (
		.kind          (kind_s1),
		.source        (src_s1),
		.in_range      (range_s1),
		.word          (cur_word),
		.new_word      (new_word),
		.source_count  (upd_count),
		.product_total (upd_total),
		.status        (upd_status),
		.flags         (upd_flags)
	);

	// Next active mask and revision as seen by this request's result
	always_comb begin
		prod_bit      = PRODUCTS'(1) << prod_s1[PA-1:0];
		active_next   = active_q;
		revision_next = revision_q;
		if (upd_flags.set_active) begin
			active_next = active_q | prod_bit;
		end
		if (upd_flags.clr_active) begin
			active_next = active_q & ~prod_bit;
		end
		if (upd_flags.bump) begin
			revision_next = revision_q + 1'b1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			vld_q      <= '0;
			active_q   <= '0;
			revision_q <= '0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (s1_adv) begin
				m_valid_q  <= 1'b1;
				active_q   <= active_next;
				revision_q <= revision_next;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (ram_we) begin
				vld_q[prod_s1[PA-1:0]] <= 1'b1;
			end
		end
	end

	// Stage 1 payload, forwarding flag and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1     <= in_kind;
			prod_s1     <= in_prod;
			src_s1      <= in_src;
			range_s1    <= in_range;
			rd_valid_s1 <= in_range && vld_q[in_idx];
			fwd_s1      <= ram_we && (prod_s1 == in_prod);
			fwd_word_s1 <= new_word;
		end
		if (s1_adv) begin
			m_data_q <= {4'b0, upd_status, MASK_W'(active_next), revision_next,
			             upd_total, upd_count};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Revision moves only when a request retires
	a_rev_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> (revision_q == $past(revision_q)))
		else $error("revision changed without a retiring request");

	// At most one product changes activity per request
	a_one_bit_change: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(active_q ^ $past(active_q)) <= 1)
		else $error("more than one active bit changed in one cycle");

	// Every revision step goes with a change of the active set
	a_rev_with_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(revision_q != $past(revision_q)) |-> (active_q != $past(active_q)))
		else $error("revision advanced with the active set unchanged");

	// Forwarding only serves a request for an in-range product
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && fwd_s1) |-> range_s1)
		else $error("forwarded word for an out-of-range product");

endmodule

FILE: tb/drt_demand_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_demand_checker
// Watches both stream channels of the demand reference tracker. Every request
// transaction is played on a private copy of the counter table, active mask
// and revision. Every answer transaction is compared field by field with the
// oldest predicted answer.
// ----------------------------------------------------------------------------
module drt_demand_checker
	import drt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    errors,
	output int                    outstanding,
	output int                    answered,
	output int                    saturated_seen,
	output int                    ignored_seen
);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] total;
		logic [REV_W-1:0]   rev;
		logic [MASK_W-1:0]  mask;
		status_t            status;
	} demand_answer_t;

	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

	logic [COUNT_W-1:0] demand [PRODUCTS_DEF][LANES];
	logic [MASK_W-1:0]  active;
	logic [REV_W-1:0]   revision;
	demand_answer_t     answers_due [$];
	demand_answer_t     due;

	function automatic logic [TOTAL_W-1:0] product_sum(input logic [PROD_W-1:0] p);
		logic [TOTAL_W-1:0] sum;
		sum = '0;
		for (int l = 0; l < LANES; l++)
			sum += TOTAL_W'(demand[p][l]);
		return sum;
	endfunction

	task automatic report_failure(input string msg);
		errors++;
		$display("%0t ns: answer %0d: %s", $time, answered, msg);
	endtask

	// Apply one request to the shadow table and queue the answer it must give
	task automatic apply_demand(input kind_t k, input logic [PROD_W-1:0] p,
			input logic [SRC_W-1:0] s);
		demand_answer_t a;
		logic [COUNT_W-1:0] cnt;
		a.status = STATUS_OK;
		cnt = demand[p][s];
		case (k)
			KIND_ACQUIRE: begin
				if (cnt == COUNT_TOP) begin
					a.status = STATUS_SATURATED;
				end else begin
					// idle product turning active moves the revision
					if (product_sum(p) == 0) begin
						revision++;
						active[p] = 1'b1;
					end
					demand[p][s] = cnt + 1'b1;
				end
			end
			KIND_RELEASE: begin
				if (cnt == 0) begin
					a.status = STATUS_REL_ZERO;
				end else begin
					demand[p][s] = cnt - 1'b1;
					if (product_sum(p) == 0) begin
						revision++;
						active[p] = 1'b0;
					end
				end
			end
			default: ; // query, and the unused kind, change nothing
		endcase
		a.count = demand[p][s];
		a.total = product_sum(p);
		a.rev   = revision;
		a.mask  = active;
		answers_due.insert(answers_due.size(), a);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (demand[p, l])
				demand[p][l] = '0;
			active   = '0;
			revision = '0;
			answers_due.delete();
			outstanding = 0;
		end else begin
			// answers first: one can never belong to a request taken at this edge
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					report_failure("answer with no request outstanding");
				end else begin
					due = answers_due.pop_front();
					if (m_tdata[15:0] !== due.count)
						report_failure($sformatf("source_count %0d, want %0d",
							m_tdata[15:0], due.count));
					if (m_tdata[33:16] !== due.total)
						report_failure($sformatf("product_total %0d, want %0d",
							m_tdata[33:16], due.total));
					if (m_tdata[65:34] !== due.rev)
						report_failure($sformatf("revision %0d, want %0d",
							m_tdata[65:34], due.rev));
					if (m_tdata[129:66] !== due.mask)
						report_failure($sformatf("active_mask %h, want %h",
							m_tdata[129:66], due.mask));
					if (m_tdata[131:130] !== due.status)
						report_failure($sformatf("status %0d, want %0d",
							m_tdata[131:130], due.status));
					if (due.status == STATUS_SATURATED)
						saturated_seen++;
					if (due.status == STATUS_REL_ZERO)
						ignored_seen++;
				end
				answered++;
			end
			// s_tdata: kind[1:0], product[7:2], source[9:8]
			if (s_tvalid && s_tready)
				apply_demand(s_tdata[1:0], s_tdata[7:2], s_tdata[9:8]);
			outstanding = answers_due.size();
		end
	end

endmodule

FILE: tb/demand_reference_tracker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_reference_tracker_top_test
// Drives request transactions into the demand reference tracker and accepts
// its answers, both sides idling at random. A short directed walk covers
// idle/active transitions, releases at zero and the unused kind; random
// traffic, mostly balanced acquire/release on a few products, follows. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module demand_reference_tracker_top_test;
	import drt_pkg::*;

	// kind code the block does not define; it must behave as a query
	localparam kind_t KIND_UNUSED = 2'd3;

	localparam logic [SRC_W-1:0] SRC_BASELINE    = 2'd0;
	localparam logic [SRC_W-1:0] SRC_APPLICATION = 2'd1;
	localparam logic [SRC_W-1:0] SRC_SUBSCRIBER  = 2'd2;
	localparam logic [SRC_W-1:0] SRC_DEPENDENT   = 2'd3;

	localparam int RANDOM_ITEMS = 800;
	localparam int MAX_IDLE     = 13;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	int errors;
	int outstanding;
	int answered;
	int saturated_seen;
	int ignored_seen;

	// set while both sides must run without idling
	bit quiet = 1'b0;

	demand_reference_tracker_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	drt_demand_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.errors         (errors),
		.outstanding    (outstanding),
		.answered       (answered),
		.saturated_seen (saturated_seen),
		.ignored_seen   (ignored_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one request; entered and left at a falling edge. tvalid is held
	// high between back-to-back requests rather than dropped and raised.
	task automatic offer(input kind_t k, input logic [PROD_W-1:0] p,
			input logic [SRC_W-1:0] s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {{(IN_DATA_W - KIND_W - PROD_W - SRC_W){1'b0}}, s, p, k};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Hold the request side until every answer has come back
	task automatic drain;
		s_tvalid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// Answer side: draw a stall per transaction, then wait for the handshake
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	initial begin
		int            quiet_left;
		int            roll;
		kind_t         k;
		logic [PROD_W-1:0] p;
		logic [SRC_W-1:0]  s;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		quiet_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed walk over the idle/active transitions
		offer(KIND_QUERY,   6'd0,  SRC_BASELINE);
		offer(KIND_RELEASE, 6'd0,  SRC_BASELINE);    // release at zero, ignored
		offer(KIND_ACQUIRE, 6'd0,  SRC_BASELINE);    // idle -> active
		offer(KIND_ACQUIRE, 6'd0,  SRC_APPLICATION); // already active
		offer(KIND_RELEASE, 6'd0,  SRC_BASELINE);    // total stays nonzero
		offer(KIND_RELEASE, 6'd0,  SRC_APPLICATION); // active -> idle
		offer(KIND_UNUSED,  6'd0,  SRC_DEPENDENT);
		offer(KIND_ACQUIRE, 6'd63, SRC_DEPENDENT);
		offer(KIND_ACQUIRE, 6'd63, SRC_SUBSCRIBER);
		offer(KIND_ACQUIRE, 6'd42, SRC_SUBSCRIBER);
		offer(KIND_ACQUIRE, 6'd21, SRC_APPLICATION);
		offer(KIND_QUERY,   6'd42, SRC_SUBSCRIBER);
		offer(KIND_RELEASE, 6'd63, SRC_DEPENDENT);
		offer(KIND_RELEASE, 6'd63, SRC_SUBSCRIBER);
		offer(KIND_RELEASE, 6'd63, SRC_BASELINE);    // release at zero
		offer(KIND_RELEASE, 6'd42, SRC_SUBSCRIBER);
		offer(KIND_RELEASE, 6'd21, SRC_APPLICATION);
		offer(KIND_UNUSED,  6'd63, SRC_BASELINE);
		drain();

		// Random traffic: mostly balanced acquire/release on a few products so
		// their totals keep crossing zero, the rest spread over all products
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (quiet_left > 0)
				quiet_left--;
			else if ($urandom_range(0, 39) == 0)
				quiet_left = $urandom_range(10, 30);
			quiet = (quiet_left != 0);
			if ($urandom_range(0, 99) == 0)
				drain();
			if ($urandom_range(0, 3) != 0)
				p = PROD_W'($urandom_range(0, 7));
			else
				p = PROD_W'($urandom_range(0, 63));
			s    = SRC_W'($urandom_range(0, 3));
			roll = $urandom_range(0, 19);
			if (roll < 9)
				k = KIND_ACQUIRE;
			else if (roll < 18)
				k = KIND_RELEASE;
			else if (roll == 18)
				k = KIND_QUERY;
			else
				k = KIND_UNUSED;
			offer(k, p, s);
		end
		quiet    = 1'b0;
		s_tvalid = 1'b0;

		// Drop nothing: wait for the last answers, then let the clock run on before reporting
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		$display("Checked %0d answers over directed and random traffic: %0d saturated acquires,",
			answered, saturated_seen);
		$display("%0d releases at zero, %0d field mismatches.", ignored_seen, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Hard stop, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("Timed out with %0d answers outstanding.", outstanding);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/drt_pkg.sv
rtl/drt_ram.sv
rtl/drt_update.sv
rtl/demand_reference_tracker_top.sv
tb/drt_demand_checker.sv
tb/demand_reference_tracker_top_test.sv
